### src/spb_pkg.sv
// shared types and constants of the sprite pixel blend core
package spb_pkg;

  localparam int ChanWidth  = 8;
  localparam int RgbWidth   = 3 * ChanWidth;
  localparam int ModeWidth  = 2;
  localparam int RegIdxWidth = 3;
  localparam int RegDataWidth = RgbWidth;

  // blit modes
  localparam logic [ModeWidth-1:0] MODE_COPY   = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_KEY    = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_BLEND  = 2'd2;
  localparam logic [ModeWidth-1:0] MODE_SPRITE = 2'd3;

  // register indexes
  localparam logic [RegIdxWidth-1:0] REG_BLIT_MODE     = 3'd0;
  localparam logic [RegIdxWidth-1:0] REG_KEY_COLOR     = 3'd1;
  localparam logic [RegIdxWidth-1:0] REG_SHADOW_COLOR  = 3'd2;
  localparam logic [RegIdxWidth-1:0] REG_HILITE_COLOR  = 3'd3;
  localparam logic [RegIdxWidth-1:0] REG_HILITE_SHADOW = 3'd4;
  localparam logic [RegIdxWidth-1:0] REG_HILITE_ENABLE = 3'd5;

  typedef logic [ChanWidth-1:0] chan_t;
  typedef logic [RgbWidth-1:0]  rgb_t;

  typedef struct packed {
    logic [ModeWidth-1:0] blit_mode;
    rgb_t                 key_color;
    rgb_t                 shadow_color;
    rgb_t                 hilite_color;
    rgb_t                 hilite_shadow_color;
    logic                 hilite_enable;
  } cfg_t;

  typedef struct packed {
    chan_t src_red;
    chan_t src_green;
    chan_t src_blue;
    chan_t src_alpha;
    chan_t dst_red;
    chan_t dst_green;
    chan_t dst_blue;
  } pix_in_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    logic  write_enable;
  } pix_out_t;

endpackage

### src/spb_pix_in_if.sv
// input pixel channel: source rgba and destination rgb
interface spb_pix_in_if;
  logic                 valid;
  logic                 ready;
  spb_pkg::chan_t       src_red;
  spb_pkg::chan_t       src_green;
  spb_pkg::chan_t       src_blue;
  spb_pkg::chan_t       src_alpha;
  spb_pkg::chan_t       dst_red;
  spb_pkg::chan_t       dst_green;
  spb_pkg::chan_t       dst_blue;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue,
    output ready
  );
endinterface

### src/spb_pix_out_if.sv
// result pixel channel: new destination rgb and write enable
interface spb_pix_out_if;
  logic           valid;
  logic           ready;
  spb_pkg::chan_t out_red;
  spb_pkg::chan_t out_green;
  spb_pkg::chan_t out_blue;
  logic           write_enable;

  modport source (
    output valid, out_red, out_green, out_blue, write_enable,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, write_enable,
    output ready
  );
endinterface

### src/spb_cfg_if.sv
// configuration write channel
interface spb_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [spb_pkg::RegIdxWidth-1:0]     index;
  logic [spb_pkg::RegDataWidth-1:0]    data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

### src/spb_cfg_regs.sv
// configuration register file
module spb_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [spb_pkg::RegIdxWidth-1:0]  wr_index,
  input  logic [spb_pkg::RegDataWidth-1:0] wr_data,
  output spb_pkg::cfg_t                    cfg
);

  spb_pkg::cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      case (wr_index)
        spb_pkg::REG_BLIT_MODE:     cfg_next.blit_mode = wr_data[spb_pkg::ModeWidth-1:0];
        spb_pkg::REG_KEY_COLOR:     cfg_next.key_color = wr_data;
        spb_pkg::REG_SHADOW_COLOR:  cfg_next.shadow_color = wr_data;
        spb_pkg::REG_HILITE_COLOR:  cfg_next.hilite_color = wr_data;
        spb_pkg::REG_HILITE_SHADOW: cfg_next.hilite_shadow_color = wr_data;
        spb_pkg::REG_HILITE_ENABLE: cfg_next.hilite_enable = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

### src/spb_pixel_op.sv
// raster operation for one pixel: copy, colour key, alpha blend, shadow/highlight
module spb_pixel_op (
  input  spb_pkg::cfg_t     cfg,
  input  spb_pkg::pix_in_t  pix,
  output spb_pkg::pix_out_t res
);

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_SRC    = 3'd1;
  localparam logic [2:0] KIND_DARKEN = 3'd2;
  localparam logic [2:0] KIND_HILITE = 3'd3;
  localparam logic [2:0] KIND_BLEND  = 3'd4;

  spb_pkg::rgb_t src_rgb;
  logic [2:0]    kind;
  logic          is_key;
  logic          is_shadow;
  logic          is_hilite;
  logic          is_hshadow;

  assign src_rgb    = {pix.src_red, pix.src_green, pix.src_blue};
  assign is_key     = (src_rgb == cfg.key_color);
  assign is_shadow  = (src_rgb == cfg.shadow_color);
  assign is_hilite  = (src_rgb == cfg.hilite_color);
  assign is_hshadow = (src_rgb == cfg.hilite_shadow_color);

  // (d >> 2) * 3 as a shift-add
  function automatic spb_pkg::chan_t darken(input spb_pkg::chan_t d);
    logic [spb_pkg::ChanWidth-3:0] q;
    q = d[spb_pkg::ChanWidth-1:2];
    return spb_pkg::chan_t'({2'b00, q} + {1'b0, q, 1'b0});
  endfunction

  // floor(a * (d - s) / 256) + s, stays within s..d
  function automatic spb_pkg::chan_t blend(input spb_pkg::chan_t s, input spb_pkg::chan_t d,
                                           input spb_pkg::chan_t a);
    logic signed [spb_pkg::ChanWidth:0]     diff;
    logic signed [spb_pkg::ChanWidth:0]     wt;
    logic signed [2*spb_pkg::ChanWidth:0]   prod;
    logic signed [spb_pkg::ChanWidth:0]     q;
    logic signed [spb_pkg::ChanWidth:0]     sum;
    diff = $signed({1'b0, d}) - $signed({1'b0, s});
    wt   = $signed({1'b0, a});
    prod = wt * diff;
    q    = prod[2*spb_pkg::ChanWidth:spb_pkg::ChanWidth];
    sum  = q + $signed({1'b0, s});
    return sum[spb_pkg::ChanWidth-1:0];
  endfunction

  always_comb begin
    case (cfg.blit_mode)
      spb_pkg::MODE_COPY:  kind = KIND_SRC;
      spb_pkg::MODE_KEY:   kind = is_key ? KIND_NONE : KIND_SRC;
      spb_pkg::MODE_BLEND: kind = KIND_BLEND;
      default: begin
        if (is_key) begin
          kind = KIND_NONE;
        end else if (is_shadow) begin
          kind = KIND_DARKEN;
        end else if (cfg.hilite_enable) begin
          kind = is_hshadow ? KIND_HILITE : KIND_SRC;
        end else if (is_hilite) begin
          kind = KIND_NONE;
        end else begin
          kind = is_hshadow ? KIND_DARKEN : KIND_SRC;
        end
      end
    endcase
  end

  always_comb begin
    res = '0;
    case (kind)
      KIND_SRC: begin
        res.out_red      = pix.src_red;
        res.out_green    = pix.src_green;
        res.out_blue     = pix.src_blue;
        res.write_enable = 1'b1;
      end
      KIND_DARKEN: begin
        res.out_red      = darken(pix.dst_red);
        res.out_green    = darken(pix.dst_green);
        res.out_blue     = darken(pix.dst_blue);
        res.write_enable = 1'b1;
      end
      KIND_HILITE: begin
        {res.out_red, res.out_green, res.out_blue} = cfg.hilite_color;
        res.write_enable = 1'b1;
      end
      KIND_BLEND: begin
        res.out_red      = blend(pix.src_red, pix.dst_red, pix.src_alpha);
        res.out_green    = blend(pix.src_green, pix.dst_green, pix.src_alpha);
        res.out_blue     = blend(pix.src_blue, pix.dst_blue, pix.src_alpha);
        res.write_enable = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### src/sprite_pixel_blend_core.sv
// sprite pixel blend core: per-pixel raster operation of a sprite blitter
//
// pix_in takes one request per pixel: source rgba and the destination rgb it
// lands on. pix_out returns one result per request: the new destination rgb
// and write_enable; when write_enable is low the colour is zero.
// cfg writes one register per request (index 0 mode, 1 key colour, 2 shadow
// colour, 3 highlight colour, 4 highlight edge colour, 5 highlight enable);
// it is always ready and should be written only while no pixel is in flight.
// The datapath is an input register, the raster operation (one 8x9 multiply
// per channel in blend mode, colour compares otherwise) and a result register.
// An accepted request passes the input register and then the result register,
// from which pix_out presents it; throughput is one pixel per cycle while the
// receiver keeps pix_out.ready high, set by the single pass through that logic.
// When the receiver stalls, both registers fill and pix_in.ready drops; it
// follows pix_out.ready combinationally, so a new request is taken in the
// same cycle as the waiting result.
// Synchronous reset empties both registers and clears all config registers
// to zero (copy mode).
module sprite_pixel_blend_core (
  input logic            clk,
  input logic            rst,
  spb_pix_in_if.sink     pix_in,
  spb_pix_out_if.source  pix_out,
  spb_cfg_if.sink        cfg
);

  spb_pkg::cfg_t     cfg_regs;
  spb_pkg::pix_in_t  in_reg;
  spb_pkg::pix_in_t  in_word;
  spb_pkg::pix_out_t res_comb;
  spb_pkg::pix_out_t out_reg;
  logic              in_valid;
  logic              out_valid;
  logic              in_adv;
  logic              out_adv;

  assign cfg.ready = 1'b1;

  spb_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  assign in_word = '{src_red:   pix_in.src_red,
                     src_green: pix_in.src_green,
                     src_blue:  pix_in.src_blue,
                     src_alpha: pix_in.src_alpha,
                     dst_red:   pix_in.dst_red,
                     dst_green: pix_in.dst_green,
                     dst_blue:  pix_in.dst_blue};

  // result stage moves when empty or drained this cycle
  assign out_adv      = !out_valid || pix_out.ready;
  assign in_adv       = !in_valid || out_adv;
  assign pix_in.ready = in_adv;

  spb_pixel_op u_pixel_op (
    .cfg (cfg_regs),
    .pix (in_reg),
    .res (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid <= pix_in.valid;
      end
      if (out_adv) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && pix_in.valid) begin
      in_reg <= in_word;
    end
    if (out_adv && in_valid) begin
      out_reg <= res_comb;
    end
  end

  assign pix_out.valid        = out_valid;
  assign pix_out.out_red      = out_reg.out_red;
  assign pix_out.out_green    = out_reg.out_green;
  assign pix_out.out_blue     = out_reg.out_blue;
  assign pix_out.write_enable = out_reg.write_enable;

endmodule
